FILE: hdl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants of the bitmap block allocator
// Item and result layouts, op and status codes, datapath command set.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int MAX_BLOCKS = 65536;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = 17;
    localparam int POS_W      = IDX_W + 2;
    localparam int WORD_W     = 32;
    localparam int WORD_BITS  = $clog2(WORD_W);
    localparam int LANE_W     = 8;
    localparam int LANE_BITS  = WORD_BITS - 3;
    localparam int DEPTH      = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_ADD   = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FAIL    = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    typedef struct packed {
        logic [1:0]       op;
        logic [15:0]      start_block;
        logic [CNT_W-1:0] block_count;
    } t_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [15:0]      alloc_index;
        logic [CNT_W-1:0] free_count;
        logic [CNT_W-1:0] used_count;
    } t_result;

    typedef enum logic [3:0] {
        C_NONE,
        C_INIT,
        C_LOAD,
        C_PASS1,
        C_PASS2,
        C_SCAN,
        C_CLEAR,
        C_FILL,
        C_FINISH
    } t_dp_cmd;

    typedef struct packed {
        logic init_done;
        logic alloc_go;
        logic fill_go;
        logic found;
        logic scan_end;
        logic fill_end;
    } t_dp_stat;

endpackage

FILE: hdl/bba_dp.sv
// ----------------------------------------------------------------------------
// bba_dp: allocator datapath
// Used-bit memory, scan and fill engines, cursor, counters, result register.
// ----------------------------------------------------------------------------
module bba_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bba_pkg::t_dp_cmd          i_cmd,
    input  bba_pkg::t_item            i_item,
    input  logic                      i_cfg_we,
    input  logic [bba_pkg::CNT_W-1:0] i_cfg_wdata,
    output bba_pkg::t_dp_stat         o_stat,
    output bba_pkg::t_result          o_result,
    output logic                      o_strobe
);
    import bba_pkg::*;

    function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_sub(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
        return (b > a) ? '0 : a - b;
    endfunction

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;
    logic [ADDR_W-1:0] r_tag;
    logic              r_loaded;
    logic [ADDR_W-1:0] r_init_addr;
    logic [CNT_W-1:0]  r_total;
    logic [IDX_W:0]    r_cursor;
    logic [CNT_W-1:0]  r_free;
    logic [CNT_W-1:0]  r_used;
    logic              r_found;
    logic              r_strobe;
    t_item             r_item;
    t_result           r_result;
    logic [POS_W-1:0]  r_cur;
    logic [POS_W-1:0]  r_end;
    logic [POS_W-1:0]  r_lo;
    logic [POS_W-1:0]  r_hi;
    logic [CNT_W-1:0]  r_run;
    logic              r_set;

    logic [POS_W-1:0]  lim;
    logic [POS_W-1:0]  cur_min;
    logic [ADDR_W-1:0] cur_word;
    logic [ADDR_W-1:0] lo_word;
    logic              scan_end;
    logic              fill_end;
    logic              cur_hit;
    logic              lo_hit;

    logic              we;
    logic              re;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [WORD_W-1:0] wdata;

    logic [POS_W-1:0]  base;
    logic [LANE_W-1:0] chunk;
    logic              ev_hit;
    logic [2:0]        ev_k;
    logic [CNT_W-1:0]  ev_run;
    logic [POS_W-1:0]  hit_end;
    logic [POS_W-1:0]  run_first;

    logic [POS_W-WORD_BITS-1:0] lo_up;
    logic [POS_W-1:0]  lo_next;
    logic [WORD_W-1:0] m_lo;
    logic [WORD_W-1:0] m_hi;
    logic [WORD_W-1:0] mask;
    logic [POS_W:0]    clr_end;
    logic [POS_W-1:0]  clr_hi;

    t_result           n_result;
    logic [IDX_W:0]    n_cursor;

    assign lim      = (POS_W'(r_total) < POS_W'(MAX_BLOCKS)) ? POS_W'(r_total)
                                                             : POS_W'(MAX_BLOCKS);
    assign cur_min  = (POS_W'(r_cursor) < lim) ? POS_W'(r_cursor) : lim;
    assign cur_word = r_cur[WORD_BITS +: ADDR_W];
    assign lo_word  = r_lo[WORD_BITS +: ADDR_W];
    assign scan_end = (r_cur >= r_end);
    assign fill_end = (r_lo >= r_hi);
    assign cur_hit  = r_loaded && (r_tag == cur_word);
    assign lo_hit   = r_loaded && (r_tag == lo_word);

    assign o_stat.init_done = (r_init_addr == ADDR_W'(DEPTH - 1));
    assign o_stat.alloc_go  = (r_item.op == OP_ALLOC) && (r_item.block_count != '0);
    assign o_stat.fill_go   = ((r_item.op == OP_FREE) && (r_item.start_block != '0))
                              || (r_item.op == OP_ADD);
    assign o_stat.found     = r_found;
    assign o_stat.scan_end  = scan_end;
    assign o_stat.fill_end  = fill_end;
    assign o_result         = r_result;
    assign o_strobe         = r_strobe;

    // Evaluate one byte lane of the held word against the running free-run length.
    assign base  = {r_cur[POS_W-1:3], 3'b000};
    assign chunk = r_rdata[{r_cur[3 +: LANE_BITS], 3'b000} +: LANE_W];

    always_comb begin
        logic [POS_W-1:0] pos;
        ev_hit = 1'b0;
        ev_k   = '0;
        ev_run = r_run;
        for (int k = 0; k < LANE_W; k++) begin
            pos = base + POS_W'(k);
            if ((3'(k) >= r_cur[2:0]) && (pos < r_end) && !ev_hit) begin
                if (!chunk[k]) begin
                    ev_run = ev_run + 1'b1;
                    if (ev_run == r_item.block_count) begin
                        ev_hit = 1'b1;
                        ev_k   = 3'(k);
                    end
                end else begin
                    ev_run = '0;
                end
            end
        end
    end

    assign hit_end = base + POS_W'(ev_k) + 1'b1;

    // First block of the found run; r_hi holds its end through the fill.
    assign run_first = r_hi - POS_W'(r_item.block_count);

    // Mask of the bits of the current word that fall inside [lo, hi).
    assign lo_up   = r_lo[POS_W-1:WORD_BITS] + 1'b1;
    assign lo_next = {lo_up, {WORD_BITS{1'b0}}};
    assign m_lo    = {WORD_W{1'b1}} << r_lo[WORD_BITS-1:0];
    assign m_hi    = (r_hi >= lo_next) ? {WORD_W{1'b1}}
                   : ((WORD_W'(1) << r_hi[WORD_BITS-1:0]) - WORD_W'(1));
    assign mask    = m_lo & m_hi;

    assign clr_end = (POS_W+1)'(r_item.start_block) + (POS_W+1)'(r_item.block_count);
    assign clr_hi  = (clr_end > (POS_W+1)'(MAX_BLOCKS)) ? POS_W'(MAX_BLOCKS)
                                                       : clr_end[POS_W-1:0];

    always_comb begin
        we    = 1'b0;
        re    = 1'b0;
        waddr = r_init_addr;
        raddr = cur_word;
        wdata = {WORD_W{1'b1}};
        unique case (i_cmd)
            C_INIT: begin
                we = 1'b1;
            end
            C_SCAN: begin
                re = !scan_end && !cur_hit;
            end
            C_FILL: begin
                raddr = lo_word;
                waddr = lo_word;
                wdata = r_set ? (r_rdata | mask) : (r_rdata & ~mask);
                we    = !fill_end && lo_hit;
                re    = !fill_end && !lo_hit;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_cursor             = r_cursor;
        n_result.status      = ST_DONE;
        n_result.alloc_index = '0;
        n_result.free_count  = r_free;
        n_result.used_count  = r_used;
        unique case (r_item.op)
            OP_ALLOC: begin
                if (r_item.block_count == '0) begin
                    n_result.status = ST_FAIL;
                end else if (r_found) begin
                    n_result.alloc_index = run_first[IDX_W-1:0];
                    n_result.used_count  = sat_add(r_used, r_item.block_count);
                    n_result.free_count  = sat_sub(r_free, r_item.block_count);
                    n_cursor             = r_hi[IDX_W:0];
                end else begin
                    n_result.status = ST_FAIL;
                    n_cursor        = cur_min[IDX_W:0];
                end
            end
            OP_FREE: begin
                if (r_item.start_block == '0) begin
                    n_result.status = ST_IGNORED;
                end else begin
                    if (r_cursor > (IDX_W+1)'(r_item.start_block)) begin
                        n_cursor = (IDX_W+1)'(r_item.start_block);
                    end
                    n_result.used_count = sat_sub(r_used, r_item.block_count);
                    n_result.free_count = sat_add(r_free, r_item.block_count);
                end
            end
            OP_ADD: begin
                n_result.free_count = sat_add(r_free, r_item.block_count);
            end
            default: begin
                n_result.status = ST_IGNORED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded    <= 1'b0;
            r_init_addr <= '0;
            r_total     <= CNT_W'(MAX_BLOCKS);
            r_cursor    <= '0;
            r_free      <= '0;
            r_used      <= '0;
            r_found     <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_strobe <= (i_cmd == C_FINISH);
            if (i_cfg_we) begin
                r_total <= i_cfg_wdata;
            end
            if (we) begin
                r_loaded <= 1'b0;
            end else if (re) begin
                r_loaded <= 1'b1;
            end
            if (i_cmd == C_INIT) begin
                r_init_addr <= r_init_addr + 1'b1;
            end
            if (i_cmd == C_LOAD || i_cmd == C_PASS1) begin
                r_found <= 1'b0;
            end
            if (i_cmd == C_SCAN && !scan_end && cur_hit && ev_hit) begin
                r_found <= 1'b1;
            end
            if (i_cmd == C_FINISH) begin
                r_cursor <= n_cursor;
                r_free   <= n_result.free_count;
                r_used   <= n_result.used_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (re) begin
            r_tag <= raddr;
        end
        unique case (i_cmd)
            C_LOAD: begin
                r_item <= i_item;
            end
            C_PASS1: begin
                r_cur <= POS_W'(r_cursor);
                r_end <= lim;
                r_run <= '0;
            end
            C_PASS2: begin
                r_cur <= '0;
                r_end <= cur_min;
                r_run <= '0;
            end
            C_SCAN: begin
                if (!scan_end && cur_hit) begin
                    r_run <= ev_run;
                    if (ev_hit) begin
                        r_hi  <= hit_end;
                        r_lo  <= hit_end - POS_W'(r_item.block_count);
                        r_set <= 1'b1;
                    end else begin
                        r_cur <= base + POS_W'(LANE_W);
                    end
                end
            end
            C_CLEAR: begin
                r_lo  <= POS_W'(r_item.start_block);
                r_hi  <= clr_hi;
                r_set <= 1'b0;
            end
            C_FILL: begin
                if (we) begin
                    r_lo <= lo_next;
                end
            end
            C_FINISH: begin
                r_result <= n_result;
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: hdl/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl: allocator controller
// Sequences memory init, dispatch, the two scan passes and run fills.
// ----------------------------------------------------------------------------
module bba_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  bba_pkg::t_dp_stat  i_stat,
    output bba_pkg::t_dp_cmd   o_cmd,
    output logic               busy
);
    import bba_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_SCAN1,
        S_SCAN2,
        S_FILL
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    assign busy = r_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = C_NONE;
        unique case (r_state)
            S_INIT: begin
                o_cmd = C_INIT;
                if (i_stat.init_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd   = C_LOAD;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                priority if (i_stat.alloc_go) begin
                    o_cmd   = C_PASS1;
                    n_state = S_SCAN1;
                end else if (i_stat.fill_go) begin
                    o_cmd   = C_CLEAR;
                    n_state = S_FILL;
                end else begin
                    o_cmd   = C_FINISH;
                    n_state = S_IDLE;
                end
            end
            S_SCAN1: begin
                priority if (i_stat.found) begin
                    n_state = S_FILL;
                end else if (i_stat.scan_end) begin
                    o_cmd   = C_PASS2;
                    n_state = S_SCAN2;
                end else begin
                    o_cmd = C_SCAN;
                end
            end
            S_SCAN2: begin
                priority if (i_stat.found) begin
                    n_state = S_FILL;
                end else if (i_stat.scan_end) begin
                    o_cmd   = C_FINISH;
                    n_state = S_IDLE;
                end else begin
                    o_cmd = C_SCAN;
                end
            end
            S_FILL: begin
                if (i_stat.fill_end) begin
                    o_cmd   = C_FINISH;
                    n_state = S_IDLE;
                end else begin
                    o_cmd = C_FILL;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_busy  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

endmodule

FILE: hdl/bitmap_block_allocator_top.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator_top: next-fit bitmap block allocator
// Keeps a used bit per block, a next-fit cursor and free/used block counts.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Its result appears on
// o_result with o_strobe high for exactly one cycle and cannot be held off,
// so capture it on that cycle. After reset the block sweeps its used-bit
// memory to all ones, one 32-bit word per cycle, with busy high;
// configuration writes are taken throughout. Each item passes a dispatch
// step, then its work, then a closing step: a free or add reads and writes
// each memory word the run touches; an alloc scans 8 blocks per cycle,
// pausing to read each 32-block word, from the cursor to the limit and, on a
// miss, again from block 0 up to the old cursor, then marks the run found
// word by word. Scan time thus depends on fragmentation. The result is
// strobed in the same cycle in which busy drops, and the next item may start
// in that same cycle.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  bba_pkg::t_item            i_item,
    output bba_pkg::t_result          o_result,
    output logic                      o_strobe,
    input  logic                      i_cfg_we,
    input  logic [bba_pkg::CNT_W-1:0] i_cfg_wdata
);
    import bba_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequence init, scans and fills.
    bba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // Hold the map, cursor, counters and result.
    bba_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_stat      (stat),
        .o_result    (o_result),
        .o_strobe    (o_strobe)
    );

endmodule
